FILE: sv/two_image_pixel_compositor_core_macros.svh
// Assertion macros shared by the compositor RTL.
`ifndef TWO_IMAGE_PIXEL_COMPOSITOR_CORE_MACROS_SVH
`define TWO_IMAGE_PIXEL_COMPOSITOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TIPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define TIPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tipc_pkg.sv
// Shared types and constants of the two-image pixel compositor.
package tipc_pkg;

    localparam int PIX_W   = 16;
    localparam int ALPHA_W = 17;
    localparam int TILE_W  = 13;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    // Mode register codes
    localparam logic [MODE_W-1:0] MODE_SINGLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECKER = 2'd2;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_ALPHA       = 3'd1,
        REG_FIXED_LOW   = 3'd2,
        REG_FIXED_HIGH  = 3'd3,
        REG_MOVING_LOW  = 3'd4,
        REG_MOVING_HIGH = 3'd5,
        REG_INNER_TILE  = 3'd6,
        REG_OUTER_TILE  = 3'd7
    } reg_idx_t;

    // Operation chosen by the front end for each beat
    typedef enum logic [1:0] {
        OP_SCALE  = 2'd0,
        OP_BLEND  = 2'd1,
        OP_PASS_F = 2'd2,
        OP_PASS_M = 2'd3
    } op_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ALPHA_W-1:0] alpha;
        logic [PIX_W-1:0]   fixed_low;
        logic [PIX_W-1:0]   fixed_high;
        logic [PIX_W-1:0]   moving_low;
        logic [PIX_W-1:0]   moving_high;
        logic [TILE_W-1:0]  inner_tile_size;
        logic [TILE_W-1:0]  outer_tile_size;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:            MODE_BLEND,
        alpha:           17'd32768,
        fixed_low:       16'd0,
        fixed_high:      16'hFFFF,
        moving_low:      16'd0,
        moving_high:     16'hFFFF,
        inner_tile_size: 13'd64,
        outer_tile_size: 13'd64
    };

    // Classified beat between front and back
    typedef struct packed {
        op_t              op;
        logic [PIX_W-1:0] fixed;
        logic [PIX_W-1:0] moving;
        logic             last;
    } item_t;

    // Finished result beat
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             last;
    } res_t;

endpackage

FILE: sv/two_image_pixel_compositor_core.sv
// A pushed beat is registered in the work queue and then in the result queue.
// Throughput: one pixel pair per cycle while no queue is full; the blend multiplier
// in the back end is combinational and sits between the work queue and the result queue.
// Two-entry queues let front and back stall independently.
// Reset: registers return to their defaults, tile counters to zero, queues empty.
// Top level of the two-image pixel compositor.
`include "two_image_pixel_compositor_core_macros.svh"

module two_image_pixel_compositor_core #(
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_idx,
    input  logic [tipc_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         push,
    output logic                         full,
    input  logic [tipc_pkg::PIX_W-1:0]   fixed_pixel,
    input  logic [tipc_pkg::PIX_W-1:0]   moving_pixel,
    input  logic                         end_of_line,
    input  logic                         end_of_frame,
    output logic                         empty,
    input  logic                         pop,
    output logic [tipc_pkg::PIX_W-1:0]   composite_pixel,
    output logic                         frame_last
);

    localparam int QUEUE_DEPTH = 2;

    tipc_pkg::cfg_t  cfg_reg, cfg_next;
    tipc_pkg::item_t front_item, mid_head;
    tipc_pkg::res_t  back_res, out_head;
    logic            in_accept;
    logic            at_origin;
    logic            mid_empty, mid_pop;
    logic            out_full, out_push;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (tipc_pkg::reg_idx_t'(cfg_idx))
                tipc_pkg::REG_MODE:        cfg_next.mode = cfg_wdata[1:0];
                tipc_pkg::REG_ALPHA:       cfg_next.alpha = cfg_wdata;
                tipc_pkg::REG_FIXED_LOW:   cfg_next.fixed_low = cfg_wdata[15:0];
                tipc_pkg::REG_FIXED_HIGH:  cfg_next.fixed_high = cfg_wdata[15:0];
                tipc_pkg::REG_MOVING_LOW:  cfg_next.moving_low = cfg_wdata[15:0];
                tipc_pkg::REG_MOVING_HIGH: cfg_next.moving_high = cfg_wdata[15:0];
                tipc_pkg::REG_INNER_TILE:  cfg_next.inner_tile_size = cfg_wdata[12:0];
                tipc_pkg::REG_OUTER_TILE:  cfg_next.outer_tile_size = cfg_wdata[12:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= tipc_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_accept = push && !full;

    // front end: clamp, position, classify
    tipc_front #(
        .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (in_accept),
        .fixed_pixel  (fixed_pixel),
        .moving_pixel (moving_pixel),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame),
        .item         (front_item),
        .at_origin    (at_origin)
    );

    // work queue between front and back
    tipc_fifo #(
        .WIDTH($bits(tipc_pkg::item_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (in_accept),
        .din   (front_item),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_head),
        .empty (mid_empty)
    );

    // back end: blend arithmetic
    tipc_back u_back (
        .cfg       (cfg_reg),
        .head      (mid_head),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .res       (back_res)
    );

    // result queue toward the consumer
    tipc_fifo #(
        .WIDTH($bits(tipc_pkg::res_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_head),
        .empty (empty)
    );

    assign composite_pixel = out_head.pix;
    assign frame_last      = out_head.last;

    // a frame mark sends the tile position back to the origin
    `TIPC_ASSERT_NEXT(a_frame_resets_pos, clk, rst_n, in_accept && end_of_frame, at_origin, "tile position not cleared after frame end")
    // a full work queue means the back end is held by a waiting result
    `TIPC_ASSERT_NOW(a_back_not_idle, clk, rst_n, full, !empty, "work queue full while result queue empty")

endmodule

FILE: sv/tipc_fifo.sv
// Small synchronous queue of fixed depth, first word fall-through.
module tipc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: sv/tipc_front.sv
// Front end: clamps samples, tracks tile position and classifies each beat.
module tipc_front #(
    parameter int MAX_LINE_LENGTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tipc_pkg::cfg_t             cfg,
    input  logic                       accept,
    input  logic [tipc_pkg::PIX_W-1:0] fixed_pixel,
    input  logic [tipc_pkg::PIX_W-1:0] moving_pixel,
    input  logic                       end_of_line,
    input  logic                       end_of_frame,
    output tipc_pkg::item_t            item,
    output logic                       at_origin
);

    localparam int OW = $clog2(MAX_LINE_LENGTH);
    localparam int LW = OW + 1;

    logic [OW-1:0] inner_offset_reg, inner_offset_next;
    logic [OW-1:0] outer_offset_reg, outer_offset_next;
    logic          inner_parity_reg, inner_parity_next;
    logic          outer_parity_reg, outer_parity_next;
    logic [LW-1:0] inner_len, outer_len;
    logic          inner_wrap, outer_wrap;
    logic [tipc_pkg::PIX_W-1:0] f_clamp, m_clamp;

    // zero acts as one, oversize acts as the line limit
    function automatic logic [LW-1:0] tile_len(input logic [tipc_pkg::TILE_W-1:0] size);
        logic [LW-1:0] len;
        if (size == '0)
        begin
            len = LW'(1);
        end
        else if (32'(size) > 32'(MAX_LINE_LENGTH))
        begin
            len = LW'(MAX_LINE_LENGTH);
        end
        else
        begin
            len = LW'(size);
        end
        return len;
    endfunction

    function automatic logic [tipc_pkg::PIX_W-1:0] clamp(
        input logic [tipc_pkg::PIX_W-1:0] x,
        input logic [tipc_pkg::PIX_W-1:0] lo,
        input logic [tipc_pkg::PIX_W-1:0] hi
    );
        logic [tipc_pkg::PIX_W-1:0] r;
        if (x < lo)
        begin
            r = lo;
        end
        else if (x > hi)
        begin
            r = hi;
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    assign inner_len  = tile_len(cfg.inner_tile_size);
    assign outer_len  = tile_len(cfg.outer_tile_size);
    assign inner_wrap = ({1'b0, inner_offset_reg} + 1'b1) >= inner_len;
    assign outer_wrap = ({1'b0, outer_offset_reg} + 1'b1) >= outer_len;
    assign f_clamp    = clamp(fixed_pixel, cfg.fixed_low, cfg.fixed_high);
    assign m_clamp    = clamp(moving_pixel, cfg.moving_low, cfg.moving_high);
    assign at_origin  = (inner_offset_reg == '0) && (outer_offset_reg == '0)
                        && !inner_parity_reg && !outer_parity_reg;

    // classify with the position as it stood before this beat
    always_comb
    begin
        item.fixed  = f_clamp;
        item.moving = m_clamp;
        item.last   = end_of_frame;
        case (cfg.mode)
            tipc_pkg::MODE_SINGLE:  item.op = tipc_pkg::OP_SCALE;
            tipc_pkg::MODE_CHECKER: item.op = (inner_parity_reg == outer_parity_reg) ?
                                              tipc_pkg::OP_PASS_F : tipc_pkg::OP_PASS_M;
            default:                item.op = tipc_pkg::OP_BLEND;
        endcase
    end

    // position counters: frame mark wins over line mark
    always_comb
    begin
        inner_offset_next = inner_offset_reg;
        inner_parity_next = inner_parity_reg;
        outer_offset_next = outer_offset_reg;
        outer_parity_next = outer_parity_reg;
        if (accept)
        begin
            if (end_of_frame)
            begin
                inner_offset_next = '0;
                inner_parity_next = 1'b0;
                outer_offset_next = '0;
                outer_parity_next = 1'b0;
            end
            else if (end_of_line)
            begin
                inner_offset_next = '0;
                inner_parity_next = 1'b0;
                if (outer_wrap)
                begin
                    outer_offset_next = '0;
                    outer_parity_next = !outer_parity_reg;
                end
                else
                begin
                    outer_offset_next = outer_offset_reg + 1'b1;
                end
            end
            else if (inner_wrap)
            begin
                inner_offset_next = '0;
                inner_parity_next = !inner_parity_reg;
            end
            else
            begin
                inner_offset_next = inner_offset_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_offset_reg <= '0;
            inner_parity_reg <= 1'b0;
            outer_offset_reg <= '0;
            outer_parity_reg <= 1'b0;
        end
        else
        begin
            inner_offset_reg <= inner_offset_next;
            inner_parity_reg <= inner_parity_next;
            outer_offset_reg <= outer_offset_next;
            outer_parity_reg <= outer_parity_next;
        end
    end

endmodule

FILE: sv/tipc_back.sv
// Back end: moves beats from the work queue to the result queue and scales, blends or passes them.
module tipc_back (
    input  tipc_pkg::cfg_t  cfg,
    input  tipc_pkg::item_t head,
    input  logic            mid_empty,
    output logic            mid_pop,
    input  logic            out_full,
    output logic            out_push,
    output tipc_pkg::res_t  res
);

    logic [tipc_pkg::ALPHA_W-1:0] a_sat;
    logic signed [17:0]           a_s;
    logic signed [16:0]           diff;
    logic [31:0]                  base;
    logic signed [34:0]           prod;
    logic signed [34:0]           acc;

    // transfer whenever a beat waits and the result queue has room
    assign mid_pop  = !mid_empty && !out_full;
    assign out_push = mid_pop;

    // alpha above one saturates
    assign a_sat = (cfg.alpha > tipc_pkg::ALPHA_ONE) ? tipc_pkg::ALPHA_ONE : cfg.alpha;
    assign a_s   = $signed({1'b0, a_sat});

    // a*f + (1-a)*m folded to m*one + a*(f-m): one multiplier
    always_comb
    begin
        if (head.op == tipc_pkg::OP_SCALE)
        begin
            diff = $signed({1'b0, head.fixed});
            base = '0;
        end
        else
        begin
            diff = $signed({1'b0, head.fixed}) - $signed({1'b0, head.moving});
            base = {head.moving, 16'h0000};
        end
    end

    assign prod = a_s * diff;
    assign acc  = prod + $signed({3'b000, base}) + $signed(35'd32768);

    // select result by operation
    always_comb
    begin
        res.last = head.last;
        case (head.op)
            tipc_pkg::OP_PASS_F: res.pix = head.fixed;
            tipc_pkg::OP_PASS_M: res.pix = head.moving;
            default:             res.pix = acc[31:16];
        endcase
    end

endmodule
